// ===== src/feal_ks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feal_ks_pkg
// Shared constants, types and the FEAL key function for the key schedule.
// ----------------------------------------------------------------------------
package feal_ks_pkg;

   // number of subkey words per key, one cell per round
   localparam int ROUNDS = 6;

   localparam int KEY_W    = 64;
   localparam int WORD_W   = 32;
   localparam int IDX_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int REQ_TD_W = 64;
   // subkey word and index packed, padded to whole bytes
   localparam int RSP_TD_W = ((WORD_W + IDX_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
   localparam int PAD_W    = RSP_TD_W - WORD_W - IDX_W;

   // round state carried from cell to cell
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] d;
   } ks_state_type;

   // s-box: add with carry-in t, keep 8 bits, rotate left by two
   function automatic logic [BYTE_W-1:0] sbox_t(
      input logic [BYTE_W-1:0] x,
      input logic [BYTE_W-1:0] y,
      input logic              t
   );
      logic [BYTE_W-1:0] s;
      s = x + y + {{(BYTE_W-1){1'b0}}, t};
      return {s[BYTE_W-3:0], s[BYTE_W-1:BYTE_W-2]};
   endfunction

   // key function fk, byte 0 least significant
   function automatic logic [WORD_W-1:0] key_fn(
      input logic [WORD_W-1:0] a,
      input logic [WORD_W-1:0] b
   );
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] f0;
      logic [BYTE_W-1:0] f1;
      logic [BYTE_W-1:0] f2;
      logic [BYTE_W-1:0] f3;
      lo = a[7:0] ^ a[15:8];
      hi = a[23:16] ^ a[31:24];
      f1 = sbox_t(lo, hi ^ b[7:0], 1'b1);
      f2 = sbox_t(hi, f1 ^ b[15:8], 1'b0);
      f0 = sbox_t(a[7:0], f1 ^ b[23:16], 1'b0);
      f3 = sbox_t(a[31:24], f2 ^ b[31:24], 1'b1);
      return {f3, f2, f1, f0};
   endfunction

endpackage
`default_nettype wire

// ===== src/feal_ks_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feal_ks_cell
// One round of the key schedule: holds a round state, computes fk and hands
// the updated state to the next cell.
// ----------------------------------------------------------------------------
module feal_ks_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     prev_valid,
   input  wire feal_ks_pkg::ks_state_type prev_state,
   output      logic                     valid,
   output      logic [feal_ks_pkg::WORD_W-1:0] word,
   output      feal_ks_pkg::ks_state_type next_state
);
   import feal_ks_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   ks_state_type state_ff;
   ks_state_type state_in;

   // take the neighbour's item whenever the chain moves
   always_comb begin
      valid_in = advance ? prev_valid : valid_ff;
      state_in = advance ? prev_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   // round function and shifted state
   always_comb begin
      word         = key_fn(state_ff.a, state_ff.b ^ state_ff.d);
      next_state.d = state_ff.a;
      next_state.a = state_ff.b;
      next_state.b = word;
   end

   assign valid = valid_ff;

endmodule
`default_nettype wire

// ===== src/feal_key_schedule.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feal_key_schedule
// FEAL key schedule: one 64-bit key in, ROUNDS 32-bit subkey words out.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req_    | in  | tdata[63:0] key
//  rsp_    | out | tdata[31:0] subkey_word, [34:32] word_index; tlast last
//
//  A key walks down a chain of ROUNDS round cells, one cell per cycle while
//  rsp_tready does not stall; the cell it sits in yields that round's word into
//  the output register. One word leaves per cycle unless stalled; the next key
//  is taken at the edge where the previous one leaves the last cell.
//  Reset (synchronous) empties the chain and the output register.
//  A stall on rsp_tready freezes the whole chain.
// ----------------------------------------------------------------------------
module feal_key_schedule (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [feal_ks_pkg::REQ_TD_W-1:0]  req_tdata,  // key
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [feal_ks_pkg::RSP_TD_W-1:0]  rsp_tdata,  // subkey_word, word_index
   output      logic                              rsp_tlast   // last
);
   import feal_ks_pkg::*;

   logic                       advance;
   logic                       busy;
   logic                       any_valid;
   logic                       accept;
   logic [ROUNDS-1:0]          cell_valid;
   logic [WORD_W-1:0]          cell_word  [ROUNDS];
   ks_state_type               cell_next  [ROUNDS];
   ks_state_type               load_state;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [WORD_W-1:0]          rsp_word_ff;
   logic [WORD_W-1:0]          rsp_word_in;
   logic [IDX_W-1:0]           rsp_idx_ff;
   logic [IDX_W-1:0]           rsp_idx_in;
   logic                       rsp_last_ff;
   logic                       rsp_last_in;

   // chain moves when the output register is free or being drained
   assign advance = !rsp_valid_ff || rsp_tready;

   // a new key may enter once every cell but the last is empty
   always_comb begin
      busy = 1'b0;
      for (int k = 0; k < ROUNDS - 1; k++) begin
         busy = busy | cell_valid[k];
      end
   end

   assign req_tready = advance && !busy;
   assign accept     = req_tvalid && req_tready;

   // initial round state from the key
   always_comb begin
      load_state.a = req_tdata[WORD_W-1:0];
      load_state.b = req_tdata[KEY_W-1:WORD_W];
      load_state.d = '0;
   end

   // chain of round cells
   for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
      if (k == 0) begin : g_first
         feal_ks_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .prev_valid (accept),
            .prev_state (load_state),
            .valid      (cell_valid[k]),
            .word       (cell_word[k]),
            .next_state (cell_next[k])
         );
      end else begin : g_rest
         feal_ks_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .prev_valid (cell_valid[k-1]),
            .prev_state (cell_next[k-1]),
            .valid      (cell_valid[k]),
            .word       (cell_word[k]),
            .next_state (cell_next[k])
         );
      end
   end

   // pick the word of the one occupied cell
   always_comb begin
      any_valid   = |cell_valid;
      rsp_word_in = rsp_word_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      if (advance) begin
         for (int k = 0; k < ROUNDS; k++) begin
            if (cell_valid[k]) begin
               rsp_word_in = cell_word[k];
               rsp_idx_in  = IDX_W'(k);
               rsp_last_in = (k == ROUNDS - 1);
            end
         end
      end
      rsp_valid_in = advance ? any_valid : rsp_valid_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_idx_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
